// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Constants and types for the epoch to calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int unsigned NSTAGE = 8;

  // reciprocal multipliers, exact over each operand's range
  localparam logic [31:0] RECIP_60   = 32'h8888_8889;
  localparam int unsigned SHIFT_60   = 37;
  localparam logic [31:0] RECIP_24   = 32'hAAAA_AAAB;
  localparam int unsigned SHIFT_24   = 36;
  localparam logic [16:0] RECIP_7    = 17'd74899;
  localparam int unsigned SHIFT_7    = 19;
  localparam logic [15:0] RECIP_1461 = 16'd45934;
  localparam int unsigned SHIFT_1461 = 26;

  localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
  localparam logic [10:0] CYCLE_DAYS        = 11'd1461;
  localparam logic [10:0] YEAR1_START       = 11'd366;
  localparam logic [10:0] YEAR2_START       = 11'd731;
  localparam logic [10:0] YEAR3_START       = 11'd1096;
  localparam logic [7:0]  YEARS_1968_TO_2000 = 8'd32;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tod_t;

endpackage

// File: rtl/epoch_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_core
// Unix second count to calendar date, weekday and time of day.
// ----------------------------------------------------------------------------
// The input channel takes one 32-bit epoch word per cycle; a word is taken
// when in_valid is high and in_stall is low. The output channel presents the
// year offset from 2000, month, day, weekday, hours, minutes, seconds and a
// before-2000 flag as one word, taken when out_valid is high and out_stall
// is low.
// Throughput is one word per cycle while the output is not stalled, through
// an 8-stage pipeline, with the divisions by 60, 24, 7 and 1461 done as
// constant-reciprocal multiplies spread over the stages.
// Each stage holds its own valid bit. A stall on the output freezes only the
// stages that are full up to it, so empty slots fill while the receiver
// waits; in_stall rises only once every stage holds a word. No word is lost
// or repeated.
// Reset empties the pipeline: out_valid drops and in_stall goes low.
// ----------------------------------------------------------------------------
module epoch_to_calendar_core import e2c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_year_since_2000,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic        out_before_2000
);

  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !vld_r[NSTAGE] || !out_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: capture
  logic [31:0] e1_r;

  // stage 2: total minutes
  logic [26:0] qm2_r;
  logic [5:0]  elo2_r;
  logic [63:0] p60a;

  // stage 3: seconds, total hours
  logic [5:0]  sec3_r;
  logic [20:0] qh3_r;
  logic [5:0]  qmlo3_r;
  logic [63:0] p60b;
  logic [5:0]  m60a;
  logic [5:0]  sec3_nxt;

  // stage 4: minutes, day count
  logic [5:0]  sec4_r;
  logic [5:0]  min4_r;
  logic [15:0] dq4_r;
  logic [4:0]  qhlo4_r;
  logic [63:0] p24;
  logic [5:0]  min4_nxt;

  // stage 5: hours, days since 1968
  tod_t        tod5_r;
  logic [15:0] days5_r;
  logic [4:0]  m24;
  logic [4:0]  hrs5_nxt;

  // stage 6: week and cycle quotients
  tod_t        tod6_r;
  logic [15:0] days6_r;
  logic [12:0] wk6_r;
  logic [5:0]  cyc6_r;
  logic [32:0] p7;
  logic [31:0] p1461;

  // stage 7: weekday, year, day of year
  tod_t        tod7_r;
  logic [2:0]  dow7_r;
  logic [8:0]  yday7_r;
  logic        leap7_r;
  logic [6:0]  yoff7_r;
  logic        early7_r;
  logic [2:0]  wk7lo;
  logic [10:0] cyc_days;
  logic [10:0] ic;
  logic [1:0]  yiy;
  logic [10:0] ystart;
  logic [10:0] yday_full;
  logic [7:0]  ycount;
  logic        early_nxt;
  logic [7:0]  yoff_full;

  // stage 8: month, day of month
  tod_t        tod8_r;
  logic [2:0]  dow8_r;
  logic [6:0]  yoff8_r;
  logic        early8_r;
  logic [3:0]  mon8_r;
  logic [4:0]  dom8_r;
  logic [3:0]  mon_nxt;
  logic [8:0]  mstart;
  logic [8:0]  dom_full;

  assign p60a = e1_r * RECIP_60;

  assign p60b     = qm2_r * RECIP_60;
  assign m60a     = 6'(qm2_r[5:0] * 6'd60);
  assign sec3_nxt = elo2_r - m60a;

  assign p24      = qh3_r * RECIP_24;
  assign min4_nxt = qmlo3_r - 6'(qh3_r[5:0] * 6'd60);

  assign m24      = 5'(dq4_r[4:0] * 5'd24);
  assign hrs5_nxt = qhlo4_r - m24;

  assign p7    = days5_r * RECIP_7;
  assign p1461 = days5_r * RECIP_1461;

  always_comb begin
    wk7lo    = 3'(wk6_r[2:0] * 3'd7);
    cyc_days = {5'b0, cyc6_r} * CYCLE_DAYS;
    ic       = days6_r[10:0] - cyc_days;
    if (ic >= YEAR3_START) begin
      yiy    = 2'd3;
      ystart = YEAR3_START;
    end else if (ic >= YEAR2_START) begin
      yiy    = 2'd2;
      ystart = YEAR2_START;
    end else if (ic >= YEAR1_START) begin
      yiy    = 2'd1;
      ystart = YEAR1_START;
    end else begin
      yiy    = 2'd0;
      ystart = '0;
    end
    yday_full = ic - ystart;
    ycount    = {cyc6_r, 2'b00} + {6'b0, yiy};
    early_nxt = ycount < YEARS_1968_TO_2000;
    yoff_full = early_nxt ? 8'd0 : ycount - YEARS_1968_TO_2000;
  end

  always_comb begin
    logic [8:0] st;
    mon_nxt = 4'd1;
    mstart  = '0;
    for (int i = 0; i < 12; i++) begin
      st = MONTH_START[i] + {8'b0, leap7_r && (i >= 2)};
      if (yday7_r >= st) begin
        mon_nxt = 4'(i + 1);
        mstart  = st;
      end
    end
    dom_full = yday7_r - mstart + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      e1_r <= in_epoch_seconds;
    end
    if (adv[2]) begin
      qm2_r  <= p60a[SHIFT_60+26:SHIFT_60];
      elo2_r <= e1_r[5:0];
    end
    if (adv[3]) begin
      sec3_r  <= sec3_nxt;
      qh3_r   <= p60b[SHIFT_60+20:SHIFT_60];
      qmlo3_r <= qm2_r[5:0];
    end
    if (adv[4]) begin
      sec4_r  <= sec3_r;
      min4_r  <= min4_nxt;
      dq4_r   <= p24[SHIFT_24+15:SHIFT_24];
      qhlo4_r <= qh3_r[4:0];
    end
    if (adv[5]) begin
      tod5_r.seconds <= sec4_r;
      tod5_r.minutes <= min4_r;
      tod5_r.hours   <= hrs5_nxt;
      days5_r        <= dq4_r + DAYS_1968_TO_1970;
    end
    if (adv[6]) begin
      tod6_r  <= tod5_r;
      days6_r <= days5_r;
      wk6_r   <= p7[SHIFT_7+12:SHIFT_7];
      cyc6_r  <= p1461[SHIFT_1461+5:SHIFT_1461];
    end
    if (adv[7]) begin
      tod7_r   <= tod6_r;
      dow7_r   <= days6_r[2:0] - wk7lo + 3'd1;
      yday7_r  <= yday_full[8:0];
      leap7_r  <= (yiy == 2'd0);
      yoff7_r  <= yoff_full[6:0];
      early7_r <= early_nxt;
    end
    if (adv[8]) begin
      tod8_r   <= tod7_r;
      dow8_r   <= dow7_r;
      yoff8_r  <= yoff7_r;
      early8_r <= early7_r;
      mon8_r   <= mon_nxt;
      dom8_r   <= dom_full[4:0];
    end
  end

  assign out_valid           = vld_r[NSTAGE];
  assign out_year_since_2000 = yoff8_r;
  assign out_month           = mon8_r;
  assign out_day_of_month    = dom8_r;
  assign out_weekday         = dow8_r;
  assign out_hours           = tod8_r.hours;
  assign out_minutes         = tod8_r.minutes;
  assign out_seconds         = tod8_r.seconds;
  assign out_before_2000     = early8_r;

endmodule

// File: rtl/e2c_chk.sv
// ----------------------------------------------------------------------------
// e2c_chk
// Port-level checks for the epoch to calendar converter, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2c_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_epoch_seconds,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_year_since_2000,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month,
  input logic [2:0]  out_weekday,
  input logic [4:0]  out_hours,
  input logic [5:0]  out_minutes,
  input logic [5:0]  out_seconds,
  input logic        out_before_2000
);

  logic [38:0] out_word;
  logic        fields_ok;
  logic        out_wait;
  logic        in_wait;

  assign out_word = {out_year_since_2000, out_month, out_day_of_month, out_weekday,
                     out_hours, out_minutes, out_seconds, out_before_2000};
  assign out_wait = out_valid && out_stall;
  assign in_wait  = in_valid && in_stall;

  assign fields_ok = (out_month >= 4'd1) && (out_month <= 4'd12) &&
                     (out_day_of_month >= 5'd1) &&
                     (out_weekday >= 3'd1) && (out_weekday <= 3'd7) &&
                     (out_hours <= 5'd23) && (out_minutes <= 6'd59) &&
                     (out_seconds <= 6'd59);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_word),
               "stalled output word changed")
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_epoch_seconds),
               "stalled input word changed")
  `ASSERT_IMPLIES(a_fields, clk, rst_n, out_valid, fields_ok, "output field out of range")
  `ASSERT_IMPLIES(a_early_year, clk, rst_n, out_valid && out_before_2000,
                  out_year_since_2000 == 7'd0, "year offset set before 2000")
  `ASSERT_IMPLIES(a_no_bubble_stall, clk, rst_n, !out_stall, !in_stall,
                  "input stalled while output drains")

endmodule

bind epoch_to_calendar_core e2c_chk u_e2c_chk (.*);
